// ----- sv/bounded_deque_with_filter_scan_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_FILTER_SCAN_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_FILTER_SCAN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define BDFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BDFS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BDFS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BDFS_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/bdfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bdfs_pkg
// Request and status codes, widths and the result type of the bounded deque.
// ----------------------------------------------------------------------------
package bdfs_pkg;

  localparam int DATA_W        = 32;
  localparam int REQ_W         = 4;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 6;
  localparam int DEFAULT_DEPTH = 32;
  localparam int IN_TDATA_W    = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((DATA_W + OCC_W + 7) / 8) * 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SCAN_EQ    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_SCAN_LT    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_SCAN_GT    = 4'd8;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 4'd9;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } rslt_t;

endpackage

// ----- sv/bounded_deque_with_filter_scan_top.sv -----
// Push results enter the output register from the execute state after the request
// beat is accepted, pop and peek results from the RAM read state that follows it.
// A scan of n elements reads one per cycle while no held match waits on a stalled
// output; its final result loads once the walk is done and the output is free.
// Throughput: a new request is taken the cycle after the previous final result
// loads. Synchronous reset empties the deque; the element RAM is not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_with_filter_scan_top
// Bounded double-ended queue of signed words with filter and dump scans.
// ----------------------------------------------------------------------------
module bounded_deque_with_filter_scan_top #(
  parameter int DEPTH = bdfs_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bdfs_pkg::IN_TDATA_W-1:0]      s_tdata,  // [31:0] operand_value
  input  logic [bdfs_pkg::REQ_W-1:0]           s_tuser,  // [3:0] req_type
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bdfs_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [31:0] result_value, [37:32] occupancy
  output logic [bdfs_pkg::STATUS_W-1:0]        m_tuser,  // [1:0] status
  output logic                                 m_tlast
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [bdfs_pkg::DATA_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [bdfs_pkg::DATA_W-1:0] ram_rdata;
  logic                        out_free;
  logic                        out_load;
  bdfs_pkg::rslt_t             rslt_core;
  bdfs_pkg::rslt_t             rslt_out;

  bdfs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_opv    (s_tdata[bdfs_pkg::DATA_W-1:0]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_rslt  (rslt_core)
  );

  bdfs_ram #(
    .WIDTH (bdfs_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bdfs_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .rslt_in  (rslt_core),
    .free     (out_free),
    .valid    (m_tvalid),
    .ready    (m_tready),
    .rslt_out (rslt_out)
  );

  // Pack the result beat
  assign m_tdata = bdfs_pkg::OUT_TDATA_W'({rslt_out.occupancy, rslt_out.value});
  assign m_tuser = rslt_out.status;
  assign m_tlast = rslt_out.last;

endmodule

// ----- sv/bdfs_ram.sv -----
// ----------------------------------------------------------------------------
// bdfs_ram
// Generic single-write, single-read RAM; read data registered, held when idle.
// ----------------------------------------------------------------------------
module bdfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bdfs_out_reg.sv -----
// ----------------------------------------------------------------------------
// bdfs_out_reg
// Output register between the deque control and the master stream side.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_filter_scan_top_macros.svh"

module bdfs_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bdfs_pkg::rslt_t rslt_in,
  output logic           free,
  output logic           valid,
  input  logic           ready,
  output bdfs_pkg::rslt_t rslt_out
);

  // Room for a new beat when empty or when the held beat leaves this cycle
  assign free = !valid || ready;

  // Hold valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      rslt_out <= rslt_in;
    end
  end

  `BDFS_ASSERT_IMP(a_load_free, clk, rst, load, !valid || ready, "beat loaded over a held beat")
  `BDFS_ASSERT_NXT(a_load_shows, clk, rst, load, valid, "loaded beat not offered")
  `BDFS_ASSERT_NXT(a_hold_stall, clk, rst, valid && !ready && !load, valid, "stalled beat dropped")

endmodule

// ----- sv/bdfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdfs_ctrl
// Request sequencer: ring pointers, RAM access and the scan walk.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_filter_scan_top_macros.svh"

module bdfs_ctrl #(
  parameter int DEPTH = bdfs_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdfs_pkg::REQ_W-1:0]          in_req,
  input  logic signed [bdfs_pkg::DATA_W-1:0]  in_opv,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [bdfs_pkg::DATA_W-1:0]         ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  input  logic signed [bdfs_pkg::DATA_W-1:0]  ram_rdata,
  input  logic                                out_free,
  output logic                                out_load,
  output bdfs_pkg::rslt_t                     out_rslt
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t                            state, state_next;
  logic [bdfs_pkg::REQ_W-1:0]        req;
  logic signed [bdfs_pkg::DATA_W-1:0] opv;
  logic [IDX_W-1:0]                  head, head_next;
  logic [CNT_W-1:0]                  count, count_next;
  logic [CNT_W-1:0]                  scan_idx, scan_idx_next;
  logic                              rd_pend, rd_pend_next;
  logic                              held_vld, held_vld_next;
  logic signed [bdfs_pkg::DATA_W-1:0] held_val, held_val_next;
  logic                              full;
  logic                              take;
  logic                              consume;
  logic                              more;
  logic                              is_push;

  // Ring position base + off, with base < DEPTH and off < DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign full     = (count == CNT_W'(DEPTH));
  assign more     = (scan_idx < count);
  assign is_push  = (req == bdfs_pkg::REQ_PUSH_FRONT) || (req == bdfs_pkg::REQ_PUSH_BACK);

  // Filter decision on the element just read
  always_comb begin
    case (req)
      bdfs_pkg::REQ_SCAN_EQ: take = (ram_rdata == opv);
      bdfs_pkg::REQ_SCAN_LT: take = (ram_rdata < opv);
      bdfs_pkg::REQ_SCAN_GT: take = (ram_rdata > opv);
      default:               take = 1'b1;
    endcase
  end

  // An element read is used up unless a held match must leave and cannot
  assign consume = rd_pend && (!take || !held_vld || out_free);

  // Sequencer
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    scan_idx_next   = scan_idx;
    rd_pend_next    = rd_pend;
    held_vld_next   = held_vld;
    held_val_next   = held_val;
    ram_we          = 1'b0;
    ram_waddr       = ring_add(head, count);
    ram_wdata       = opv;
    ram_re          = 1'b0;
    ram_raddr       = head;
    out_load        = 1'b0;
    out_rslt.value  = '0;
    out_rslt.status = bdfs_pkg::ST_OK;
    out_rslt.last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req) inside
          bdfs_pkg::REQ_PUSH_FRONT, bdfs_pkg::REQ_PUSH_BACK: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                out_rslt.status = bdfs_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
                if (req == bdfs_pkg::REQ_PUSH_FRONT) begin
                  head_next = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
                  ram_waddr = head_next;
                end
              end
            end
          end
          bdfs_pkg::REQ_POP_FRONT, bdfs_pkg::REQ_POP_BACK,
          bdfs_pkg::REQ_PEEK_FRONT, bdfs_pkg::REQ_PEEK_BACK: begin
            if (count == '0) begin
              if (out_free) begin
                out_load        = 1'b1;
                out_rslt.status = bdfs_pkg::ST_EMPTY;
                state_next      = S_IDLE;
              end
            end else begin
              ram_re     = 1'b1;
              state_next = S_READ;
              if ((req == bdfs_pkg::REQ_POP_BACK) || (req == bdfs_pkg::REQ_PEEK_BACK)) begin
                ram_raddr = ring_add(head, count - CNT_W'(1));
              end
              if (req == bdfs_pkg::REQ_POP_FRONT) begin
                head_next  = ring_add(head, CNT_W'(1));
                count_next = count - CNT_W'(1);
              end else if (req == bdfs_pkg::REQ_POP_BACK) begin
                count_next = count - CNT_W'(1);
              end
            end
          end
          bdfs_pkg::REQ_SCAN_EQ, bdfs_pkg::REQ_SCAN_LT,
          bdfs_pkg::REQ_SCAN_GT, bdfs_pkg::REQ_DUMP: begin
            scan_idx_next = '0;
            rd_pend_next  = 1'b0;
            held_vld_next = 1'b0;
            state_next    = S_SCAN;
          end
          default: begin
            // drop unused request codes without a result
            state_next = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        // read data holds in the RAM register until the beat goes out
        if (out_free) begin
          out_load       = 1'b1;
          out_rslt.value = ram_rdata;
          state_next     = S_IDLE;
        end
      end

      S_SCAN: begin
        // retire the pending element that the RAM read returned
        if (consume) begin
          rd_pend_next = 1'b0;
          if (take) begin
            if (held_vld) begin
              out_load       = 1'b1;
              out_rslt.value = held_val;
              out_rslt.last  = 1'b0;
            end
            held_vld_next = 1'b1;
            held_val_next = ram_rdata;
          end
        end
        // issue the next read while the walk goes on
        if (more && (!rd_pend || consume)) begin
          ram_re        = 1'b1;
          ram_raddr     = ring_add(head, scan_idx);
          scan_idx_next = scan_idx + CNT_W'(1);
          rd_pend_next  = 1'b1;
        end
        // close the scan with the held match, or report no match
        if (!rd_pend && !more && out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (held_vld) begin
            out_rslt.value = held_val;
          end else begin
            out_rslt.status = bdfs_pkg::ST_EMPTY;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_rslt.occupancy = bdfs_pkg::OCC_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      held_vld <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      rd_pend  <= rd_pend_next;
      held_vld <= held_vld_next;
    end
  end

  // Request and match payload
  always_ff @(posedge clk) begin
    held_val <= held_val_next;
    if (in_valid && in_ready) begin
      req <= in_req;
      opv <= in_opv;
    end
  end

  `BDFS_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count beyond depth")
  `BDFS_ASSERT_NXT(a_push_cnt, clk, rst, state == S_EXEC && out_free && is_push && !full,
                   count == $past(count) + CNT_W'(1), "accepted push did not grow count")
  `BDFS_ASSERT_IMP(a_rd_pend, clk, rst, rd_pend, state == S_SCAN && scan_idx != '0,
                   "pending read outside a scan")

endmodule
